// ----- sv/pke_pkg.sv -----
// Package for the particle kinematics core: field widths, the queue word and constants.
// It has no dependencies. All other files but pke_sqrt refer to it by scoped names.
`default_nettype none
package pke_pkg;

  localparam int MomW  = 20;
  localparam int MassW = 19;
  localparam int PW    = 20;
  localparam int EW    = 21;
  localparam int EtaW  = 15;
  localparam int PhiW  = 16;
  localparam int SumW  = 32;
  localparam int CntW  = 16;

  // ln(2) as Q24, and the largest eta magnitude in units of 1/1024.
  localparam logic [23:0] Ln2Q24   = 24'd11629080;
  localparam logic [15:0] EtaLimit = 16'd8192;

  // One classified particle as it waits in the queue.
  typedef struct packed {
    logic signed [MomW-1:0] px;
    logic signed [MomW-1:0] py;
    logic signed [MomW-1:0] pz;
    logic [MomW-1:0]        ax;
    logic [MomW-1:0]        ay;
    logic [MomW-1:0]        az;
    logic [MassW-1:0]       mass;
    logic                   plane_zero;
    logic                   last;
  } item_t;

  // Circular CORDIC angles atan(2^-i) in units of pi/2^31.
  function automatic logic [29:0] cordic_atan(input logic [4:0] idx);
    logic [29:0] a;
    unique case (idx)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      5'd30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- sv/pke_if.sv -----
// Handshake interfaces for the particle word and the result word.
// Depends on pke_pkg for the field widths.
`default_nettype none
interface pke_item_if;
  logic                           valid;
  logic                           ready;
  logic signed [pke_pkg::MomW-1:0] mom_x;
  logic signed [pke_pkg::MomW-1:0] mom_y;
  logic signed [pke_pkg::MomW-1:0] mom_z;
  logic [pke_pkg::MassW-1:0]       rest_mass;
  logic                           last_of_event;
  modport source(output valid, mom_x, mom_y, mom_z, rest_mass, last_of_event, input ready);
  modport sink(input valid, mom_x, mom_y, mom_z, rest_mass, last_of_event, output ready);
endinterface

interface pke_result_if;
  logic                             valid;
  logic                             ready;
  logic [pke_pkg::PW-1:0]           total_momentum;
  logic [pke_pkg::EW-1:0]           particle_energy;
  logic [pke_pkg::PW-1:0]           transverse_momentum;
  logic signed [pke_pkg::EtaW-1:0]  pseudorapidity;
  logic                             eta_saturated;
  logic signed [pke_pkg::PhiW-1:0]  azimuth;
  logic [pke_pkg::SumW-1:0]         event_energy;
  logic [pke_pkg::CntW-1:0]         event_count;
  logic                             event_done;
  modport source(output valid, total_momentum, particle_energy, transverse_momentum,
                 pseudorapidity, eta_saturated, azimuth, event_energy, event_count,
                 event_done, input ready);
  modport sink(input valid, total_momentum, particle_energy, transverse_momentum,
               pseudorapidity, eta_saturated, azimuth, event_energy, event_count,
               event_done, output ready);
endinterface
`default_nettype wire

// ----- sv/pke_sqrt.sv -----
// Digit-by-digit square root of a 42-bit radicand, rounded to nearest.
// One result bit per cycle. No package dependencies.
`default_nettype none
module pke_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [41:0] rad_i,
  output logic        done_o,
  output logic [21:0] root_o
);

  logic [41:0] x_q;
  logic [23:0] rem_q;
  logic [20:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [23:0] rem_n;
  logic [23:0] trial;

  assign rem_n = {rem_q[21:0], x_q[41:40]};
  assign trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd20) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q <= {x_q[39:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[19:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[19:0], 1'b0};
      end
    end
  end

  // The remainder is x - r*r; rounding up is due when it exceeds r.
  assign root_o = (rem_q > {3'b000, root_q}) ? {1'b0, root_q} + 22'd1 : {1'b0, root_q};
  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- sv/pke_front.sv -----
// Front end: takes particle words, forms magnitudes and flags, and holds one
// classified word until the queue takes it. Depends on pke_pkg and pke_if.
`default_nettype none
module pke_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  pke_item_if.sink       item_i,
  input  logic           full_i,
  output logic           push_o,
  output pke_pkg::item_t word_o
);

  logic           valid_q;
  pke_pkg::item_t word_q;
  pke_pkg::item_t word_d;

  always_comb begin
    word_d.px         = item_i.mom_x;
    word_d.py         = item_i.mom_y;
    word_d.pz         = item_i.mom_z;
    word_d.ax         = item_i.mom_x[pke_pkg::MomW-1] ? pke_pkg::MomW'(-item_i.mom_x)
                                                      : item_i.mom_x;
    word_d.ay         = item_i.mom_y[pke_pkg::MomW-1] ? pke_pkg::MomW'(-item_i.mom_y)
                                                      : item_i.mom_y;
    word_d.az         = item_i.mom_z[pke_pkg::MomW-1] ? pke_pkg::MomW'(-item_i.mom_z)
                                                      : item_i.mom_z;
    word_d.mass       = item_i.rest_mass;
    word_d.plane_zero = (item_i.mom_x == '0) && (item_i.mom_y == '0);
    word_d.last       = item_i.last_of_event;
  end

  assign item_i.ready = !valid_q || !full_i;
  assign push_o       = valid_q && !full_i;
  assign word_o       = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_i.ready) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      word_q <= word_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pke_fifo.sv -----
// Two-entry queue of classified particle words between front and back end.
// Depends on pke_pkg for the word type.
`default_nettype none
module pke_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pke_pkg::item_t word_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output pke_pkg::item_t word_o
);

  pke_pkg::item_t mem_q [2];
  logic           wr_q;
  logic           rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign word_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= word_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pke_back.sv -----
// Back end: squares, three square roots, CORDIC azimuth, eta through
// normalise, divide and log-by-squaring, event sums and the output register.
// Depends on pke_pkg, pke_if and pke_sqrt.
`default_nettype none
module pke_back #(
  parameter int APPROX_STEPS = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  pke_pkg::item_t word_i,
  output logic           pop_o,
  pke_result_if.source   result_o
);

  localparam int Steps = (APPROX_STEPS < 1) ? 1 : ((APPROX_STEPS > 32) ? 32 : APPROX_STEPS);
  localparam int LW    = Steps + 5;
  localparam int PRW   = LW + 25;
  localparam int SH    = Steps + 14;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_LOG  = 3'd5;
  localparam logic [2:0] S_SCAL = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]     state_q;
  logic [2:0]     state_d;
  pke_pkg::item_t cur_q;

  // squares
  logic [2:0]     mcnt_q;
  logic [19:0]    mop;
  logic [39:0]    sq_q;
  logic [40:0]    sum_q;
  logic [39:0]    pt2_q;
  logic [39:0]    p2_q;
  logic           root_start;

  // roots
  logic           dn_p, dn_e, dn_t;
  logic [21:0]    rt_p, rt_e, rt_t;
  logic           root_done_q;
  logic [19:0]    p_q, pt_q;
  logic [20:0]    e_q;
  logic [19:0]    p_cl, pt_cl;
  logic [20:0]    e_cl;

  // azimuth
  logic signed [32:0] cx_q, cy_q, cz_q;
  logic signed [32:0] sx, sy, ang, zr;
  logic [5:0]         ccnt_q;
  logic               cdone;
  logic signed [32:0] x0, y0;

  // eta
  logic [20:0]    num_q, den_q, r_q;
  logic [21:0]    r2;
  logic [4:0]     k_q;
  logic [4:0]     dcnt_q;
  logic [30:0]    q_q;
  logic [61:0]    msq;
  logic [31:0]    mt;
  logic [5:0]     lcnt_q;
  logic [Steps-1:0] frac_q;
  logic [PRW-1:0] prod_q;
  logic [PRW-1:0] rnd;
  logic [15:0]    eta_raw;
  logic [15:0]    eta_mag;
  logic           eta_sat;
  logic [14:0]    mag15;
  logic [14:0]    eta_val;

  // sums and output
  logic [31:0]    acc_q;
  logic [15:0]    cnt_q;
  logic [32:0]    esum;
  logic [31:0]    acc_n;
  logic [15:0]    cnt_n;
  logic           out_free;
  logic           out_load;
  logic           out_valid_q;

  assign pop_o      = (state_q == S_IDLE) && !empty_i;
  assign root_start = (state_q == S_MUL) && (mcnt_q == 3'd4);

  // Square operands in order: x, y, z, mass; each product is registered in sq_q before it is summed.
  always_comb begin
    unique case (mcnt_q[1:0])
      2'd0:    mop = cur_q.ax;
      2'd1:    mop = cur_q.ay;
      2'd2:    mop = cur_q.az;
      default: mop = {1'b0, cur_q.mass};
    endcase
  end

  pke_sqrt u_sqrt_p (
    .clk_i, .rst_ni, .start_i(root_start), .rad_i({2'b00, p2_q}),
    .done_o(dn_p), .root_o(rt_p)
  );
  // The mass square is still in sq_q when the roots start, so it is added here.
  pke_sqrt u_sqrt_e (
    .clk_i, .rst_ni, .start_i(root_start), .rad_i({1'b0, sum_q} + {2'b00, sq_q}),
    .done_o(dn_e), .root_o(rt_e)
  );
  pke_sqrt u_sqrt_t (
    .clk_i, .rst_ni, .start_i(root_start), .rad_i({2'b00, pt2_q}),
    .done_o(dn_t), .root_o(rt_t)
  );

  assign p_cl  = (rt_p[21:20] != 2'b00) ? 20'hFFFFF : rt_p[19:0];
  assign pt_cl = (rt_t[21:20] != 2'b00) ? 20'hFFFFF : rt_t[19:0];
  assign e_cl  = rt_e[21] ? 21'h1FFFFF : rt_e[20:0];

  // CORDIC datapath
  assign x0    = {{3{cur_q.px[19]}}, cur_q.px, 10'd0};
  assign y0    = {{3{cur_q.py[19]}}, cur_q.py, 10'd0};
  assign sx    = cx_q >>> ccnt_q[4:0];
  assign sy    = cy_q >>> ccnt_q[4:0];
  assign ang   = $signed({3'b000, pke_pkg::cordic_atan(ccnt_q[4:0])});
  assign cdone = (ccnt_q == 6'(Steps));
  assign zr    = cz_q + 33'sd32768;

  // eta datapath
  assign r2  = {r_q, 1'b0};
  assign msq = {31'd0, q_q} * {31'd0, q_q};
  assign mt  = msq[61:30];
  assign rnd = prod_q + (PRW'(1) << (SH - 1));
  assign eta_raw = rnd[SH+15:SH];

  always_comb begin
    if (pt_q == '0) begin
      eta_sat = 1'b1;
      eta_mag = (cur_q.az != '0) ? pke_pkg::EtaLimit : 16'd0;
    end else if (eta_raw > pke_pkg::EtaLimit) begin
      eta_sat = 1'b1;
      eta_mag = pke_pkg::EtaLimit;
    end else begin
      eta_sat = 1'b0;
      eta_mag = eta_raw;
    end
    mag15   = eta_mag[14:0];
    eta_val = cur_q.pz[19] ? 15'(~mag15 + 15'd1) : mag15;
  end

  // event sums
  assign esum     = {1'b0, acc_q} + {12'd0, e_q};
  assign acc_n    = esum[32] ? 32'hFFFFFFFF : esum[31:0];
  assign cnt_n    = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
  assign out_free = !out_valid_q || result_o.ready;
  assign out_load = (state_q == S_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (!empty_i) state_d = S_MUL;
      S_MUL:  if (mcnt_q == 3'd4) state_d = S_ROOT;
      S_ROOT: if (root_done_q && cdone) state_d = (pt_cl == '0) ? S_OUT : S_NORM;
      S_NORM: if ({den_q, 1'b0} > {1'b0, num_q}) state_d = S_DIV;
      S_DIV:  if (dcnt_q == 5'd29) state_d = S_LOG;
      S_LOG:  if (lcnt_q == 6'(Steps - 1)) state_d = S_SCAL;
      S_SCAL: state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mcnt_q      <= '0;
      root_done_q <= 1'b0;
      ccnt_q      <= '0;
      k_q         <= '0;
      dcnt_q      <= '0;
      lcnt_q      <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) mcnt_q <= '0;
      else if (state_q == S_MUL) mcnt_q <= mcnt_q + 3'd1;
      if (root_start) begin
        root_done_q <= 1'b0;
        ccnt_q      <= cur_q.plane_zero ? 6'(Steps) : '0;
      end else begin
        if (dn_p && dn_e && dn_t) root_done_q <= 1'b1;
        if (state_q == S_ROOT && !cdone) ccnt_q <= ccnt_q + 6'd1;
      end
      if (state_q == S_ROOT) k_q <= '0;
      else if (state_q == S_NORM && state_d == S_NORM) k_q <= k_q + 5'd1;
      if (state_q == S_NORM) dcnt_q <= '0;
      else if (state_q == S_DIV) dcnt_q <= dcnt_q + 5'd1;
      if (state_q == S_DIV) lcnt_q <= '0;
      else if (state_q == S_LOG) lcnt_q <= lcnt_q + 6'd1;
      if (out_load) begin
        acc_q <= cur_q.last ? '0 : acc_n;
        cnt_q <= cur_q.last ? '0 : cnt_n;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= word_i;

    if (state_q == S_MUL) begin
      sq_q <= mop * mop;
      unique case (mcnt_q)
        3'd1:    sum_q <= {1'b0, sq_q};
        3'd2: begin
          sum_q <= sum_q + {1'b0, sq_q};
          pt2_q <= 40'(sum_q + {1'b0, sq_q});
        end
        3'd3: begin
          sum_q <= sum_q + {1'b0, sq_q};
          p2_q  <= 40'(sum_q + {1'b0, sq_q});
        end
        3'd4:    sum_q <= sum_q + {1'b0, sq_q};
        default: sum_q <= sum_q;
      endcase
    end

    // The vector is first turned into the right half plane.
    if (root_start) begin
      if (x0 < 0) begin
        if (y0 >= 0) begin
          cx_q <= y0;
          cy_q <= -x0;
          cz_q <= 33'sd1073741824;
        end else begin
          cx_q <= -y0;
          cy_q <= x0;
          cz_q <= -33'sd1073741824;
        end
      end else begin
        cx_q <= x0;
        cy_q <= y0;
        cz_q <= '0;
      end
    end else if (state_q == S_ROOT && !cdone) begin
      if (!cy_q[32]) begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        cz_q <= cz_q + ang;
      end else begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        cz_q <= cz_q - ang;
      end
    end

    if (state_q == S_ROOT) begin
      p_q   <= p_cl;
      pt_q  <= pt_cl;
      e_q   <= e_cl;
      num_q <= {1'b0, p_cl} + {1'b0, cur_q.az};
      den_q <= {1'b0, pt_cl};
    end else if (state_q == S_NORM) begin
      if (state_d == S_NORM) begin
        den_q <= {den_q[19:0], 1'b0};
      end else begin
        r_q <= num_q - den_q;
        q_q <= 31'd1;
      end
    end else if (state_q == S_DIV) begin
      if (r2 >= {1'b0, den_q}) begin
        r_q <= 21'(r2 - {1'b0, den_q});
        q_q <= {q_q[29:0], 1'b1};
      end else begin
        r_q <= r2[20:0];
        q_q <= {q_q[29:0], 1'b0};
      end
    end else if (state_q == S_LOG) begin
      frac_q <= {frac_q[Steps-2:0], mt[31]};
      q_q    <= mt[31] ? mt[31:1] : mt[30:0];
    end

    if (state_q == S_SCAL) begin
      prod_q <= PRW'({k_q, frac_q}) * PRW'(pke_pkg::Ln2Q24);
    end

    if (out_load) begin
      result_o.total_momentum      <= p_q;
      result_o.particle_energy     <= e_q;
      result_o.transverse_momentum <= pt_q;
      result_o.pseudorapidity      <= eta_val;
      result_o.eta_saturated       <= eta_sat;
      result_o.azimuth             <= cur_q.plane_zero ? '0 : zr[31:16];
      result_o.event_energy        <= acc_n;
      result_o.event_count         <= cnt_n;
      result_o.event_done          <= cur_q.last;
    end
  end

  assign result_o.valid = out_valid_q;

  a_log_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOG) |-> q_q[30])
    else $error("log mantissa left [1,2)");

  a_eta_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.eta_saturated) |->
      (result_o.pseudorapidity <= 15'sd8192 && result_o.pseudorapidity >= -15'sd8192))
    else $error("unsaturated eta out of range");

  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_o.event_count != '0))
    else $error("result word with zero particle count");

  a_event_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_load && cur_q.last) |-> (acc_q == '0 && cnt_q == '0))
    else $error("event sums not cleared after last particle");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result word raised outside output state");

endmodule
`default_nettype wire

// ----- sv/particle_kinematics_event_energy_core.sv -----
// Particle kinematics core. Each particle word (px, py, pz, mass in MeV) yields one
// result word with |p|, energy, pT, eta in 1/1024 units, azimuth in pi/32768 units
// and the running event energy and count, cleared after the word marked last.
// A front stage accepts a word per cycle while its register is free or the two-word
// queue has room; the back end works on one particle at a time and pops the next only
// when done with it: a pop, the squares of x, y, z and mass, three parallel square
// roots with the CORDIC azimuth alongside, then normalise, divide, APPROX_STEPS log
// steps and a scale step, and the output step, which waits while the previous result
// word is not yet taken. When pT is zero the steps from normalise to scale are skipped.
// The bit-serial divider and the log squaring loop take most of the time per particle.
`default_nettype none
module particle_kinematics_event_energy_core #(
  parameter int APPROX_STEPS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pke_item_if.sink     item_i,
  pke_result_if.source result_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  pke_pkg::item_t front_word;
  pke_pkg::item_t queue_word;

  pke_front u_front (
    .clk_i, .rst_ni, .item_i, .full_i(full), .push_o(push), .word_o(front_word)
  );

  pke_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .word_i(front_word), .full_o(full),
    .pop_i(pop), .empty_o(empty), .word_o(queue_word)
  );

  pke_back #(.APPROX_STEPS(APPROX_STEPS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .word_i(queue_word), .pop_o(pop), .result_o
  );

endmodule
`default_nettype wire
